FILE: rtl/psfp_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the particulate sensor frame parser.
// No dependencies.
package psfp_pkg;

  localparam int unsigned POS_W      = 5;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned NUM_VALUES = 6;
  localparam int unsigned IDX_W      = 3;

  localparam logic [7:0] START_A     = 8'h42;
  localparam logic [7:0] START_B     = 8'h44;
  localparam logic [7:0] SECOND_BYTE = 8'h4d;

  localparam logic [POS_W-1:0] POS_START      = 5'd0;
  localparam logic [POS_W-1:0] POS_SECOND     = 5'd1;
  localparam logic [POS_W-1:0] POS_VALUE_LO   = 5'd4;
  localparam logic [POS_W-1:0] POS_VALUE_HI   = 5'd15;
  localparam logic [POS_W-1:0] POS_CHECK_HIGH = 5'd30;
  localparam logic [POS_W-1:0] POS_LAST       = 5'd31;

endpackage

FILE: rtl/particle_sensor_frame_parser.sv
`timescale 1ns / 1ps
// Particulate sensor frame parser: byte stream in, frame position and held values out.
// Depends on psfp_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one received byte (rx_byte) per request.
//   Output channel out_valid/out_ready returns one result per input byte: the next
//   expected frame position, frame_ok for a completed frame with a matching check
//   word, and the six published concentrations (already updated by that byte).
//   The byte is captured in an input register, then the position/sum/staging
//   logic updates the frame state and result register. Throughput is one byte
//   per cycle while the receiver accepts results; the single running 16-bit sum,
//   the position counter, value staging and check byte capture are the per-byte work.
//   When the receiver stalls, the result register holds and one more byte can wait in
//   the input register; in_ready drops only in reset or when both are full and blocked.
//   Synchronous reset clears position, sum, check byte, published values and both
//   valid flags; no byte is accepted during reset.
module particle_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  next_position,
  output logic        frame_ok,
  output logic [15:0] pm1_standard,
  output logic [15:0] pm25_standard,
  output logic [15:0] pm10_standard,
  output logic [15:0] pm1_ambient,
  output logic [15:0] pm25_ambient,
  output logic [15:0] pm10_ambient
);

  logic                          byte_valid;
  logic [7:0]                    byte_q;
  logic                          res_ready;
  logic                          advance;

  logic [psfp_pkg::POS_W-1:0]    frame_position;
  logic [psfp_pkg::POS_W-1:0]    frame_position_next;
  logic [psfp_pkg::SUM_W-1:0]    byte_sum;
  logic [psfp_pkg::SUM_W-1:0]    byte_sum_next;
  logic [7:0]                    check_high_byte;
  logic [psfp_pkg::VALUE_W-1:0]  staged_values    [psfp_pkg::NUM_VALUES];
  logic [psfp_pkg::VALUE_W-1:0]  published_values [psfp_pkg::NUM_VALUES];

  logic                          ok_next;
  logic                          stage_we;
  logic [psfp_pkg::POS_W-1:0]    value_off;
  logic [psfp_pkg::IDX_W-1:0]    stage_idx;
  logic [psfp_pkg::SUM_W-1:0]    check_word;

  assign res_ready = !out_valid || out_ready;
  assign in_ready  = !rst && (!byte_valid || res_ready);
  assign advance   = byte_valid && res_ready;

  assign value_off  = frame_position - psfp_pkg::POS_VALUE_LO;
  assign stage_idx  = value_off[psfp_pkg::IDX_W:1];
  assign check_word = {check_high_byte, byte_q};

  always_comb begin
    frame_position_next = frame_position + 5'd1;
    byte_sum_next       = byte_sum + {8'd0, byte_q};
    ok_next             = 1'b0;
    stage_we            = 1'b0;
    priority if (frame_position == psfp_pkg::POS_START) begin
      byte_sum_next = {8'd0, byte_q};
      if (byte_q != psfp_pkg::START_A && byte_q != psfp_pkg::START_B) begin
        frame_position_next = psfp_pkg::POS_START;
        byte_sum_next       = byte_sum;
      end
    end else if (frame_position == psfp_pkg::POS_SECOND) begin
      if (byte_q != psfp_pkg::SECOND_BYTE) begin
        frame_position_next = psfp_pkg::POS_START;
        byte_sum_next       = byte_sum;
      end
    end else if (frame_position < psfp_pkg::POS_CHECK_HIGH) begin
      stage_we = (frame_position >= psfp_pkg::POS_VALUE_LO) &&
                 (frame_position <= psfp_pkg::POS_VALUE_HI);
    end else begin
      byte_sum_next = byte_sum;
      ok_next       = (frame_position == psfp_pkg::POS_LAST) && (check_word == byte_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid      <= 1'b0;
      out_valid       <= 1'b0;
      frame_ok        <= 1'b0;
      frame_position  <= psfp_pkg::POS_START;
      byte_sum        <= '0;
      check_high_byte <= '0;
      for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
        published_values[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (res_ready) begin
        out_valid <= byte_valid;
      end
      if (advance) begin
        frame_position <= frame_position_next;
        byte_sum       <= byte_sum_next;
        frame_ok       <= ok_next;
        if (frame_position == psfp_pkg::POS_CHECK_HIGH) begin
          check_high_byte <= byte_q;
        end
        if (ok_next) begin
          for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
            published_values[i] <= staged_values[i];
          end
        end
      end
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
    if (advance && stage_we) begin
      staged_values[stage_idx] <= {staged_values[stage_idx][7:0], byte_q};
    end
  end

  assign next_position = frame_position;
  assign pm1_standard  = published_values[0];
  assign pm25_standard = published_values[1];
  assign pm10_standard = published_values[2];
  assign pm1_ambient   = published_values[3];
  assign pm25_ambient  = published_values[4];
  assign pm10_ambient  = published_values[5];

  a_ok_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_ok) |-> (next_position == psfp_pkg::POS_START))
    else $error("frame_ok with nonzero next position");

  a_ok_only_at_last: assert property (@(posedge clk) disable iff (rst)
    (advance && frame_position != psfp_pkg::POS_LAST) |=> !frame_ok)
    else $error("frame_ok from a byte other than the last");

  a_publish_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(pm25_ambient)) |-> (frame_ok && out_valid))
    else $error("published value changed without an accepted frame");

endmodule

FILE: test/particle_sensor_frame_parser_checker.sv
`timescale 1ns / 1ps
// Result checker for the particulate sensor frame parser: follows both request channels,
// predicts every result from the accepted bytes and compares it field by field.
// Depends on psfp_pkg.
module particle_sensor_frame_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  next_position,
  input  logic        frame_ok,
  input  logic [15:0] pm1_standard,
  input  logic [15:0] pm25_standard,
  input  logic [15:0] pm10_standard,
  input  logic [15:0] pm1_ambient,
  input  logic [15:0] pm25_ambient,
  input  logic [15:0] pm10_ambient,
  output int          pending_results,
  output int          mismatch_count
);

  typedef logic [psfp_pkg::NUM_VALUES-1:0][psfp_pkg::VALUE_W-1:0] value_set_t;

  typedef struct packed {
    logic [psfp_pkg::POS_W-1:0] next_position;
    logic                       frame_ok;
    value_set_t                 values;
  } parse_result_t;

  // parser state as the block should hold it
  logic [psfp_pkg::POS_W-1:0] frame_pos;
  logic [psfp_pkg::SUM_W-1:0] byte_total;
  logic [7:0]                 check_hi;
  value_set_t                 staged;
  value_set_t                 published;

  parse_result_t    expected_q[$];
  int               errors = 0;

  string value_name [psfp_pkg::NUM_VALUES] = '{"pm1_standard", "pm25_standard",
                                               "pm10_standard", "pm1_ambient",
                                               "pm25_ambient", "pm10_ambient"};

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    parse_result_t              r;
    logic                       reject;
    logic [psfp_pkg::IDX_W-1:0] k;
    reject  = 1'b0;
    r.frame_ok = 1'b0;
    if (frame_pos == psfp_pkg::POS_START) begin
      if (b != psfp_pkg::START_A && b != psfp_pkg::START_B) reject = 1'b1;
      else byte_total = psfp_pkg::SUM_W'(b);
    end else if (frame_pos == psfp_pkg::POS_SECOND) begin
      if (b != psfp_pkg::SECOND_BYTE) reject = 1'b1;
      else byte_total = byte_total + psfp_pkg::SUM_W'(b);
    end else if (frame_pos < psfp_pkg::POS_CHECK_HIGH) begin
      byte_total = byte_total + psfp_pkg::SUM_W'(b);
      if (frame_pos >= psfp_pkg::POS_VALUE_LO && frame_pos <= psfp_pkg::POS_VALUE_HI) begin
        k = psfp_pkg::IDX_W'((frame_pos - psfp_pkg::POS_VALUE_LO) >> 1);
        staged[k] = {staged[k][7:0], b};
      end
    end else if (frame_pos == psfp_pkg::POS_CHECK_HIGH) begin
      check_hi = b;
    end else if ({check_hi, b} == byte_total) begin
      r.frame_ok = 1'b1;
      published  = staged;
    end
    frame_pos       = reject ? psfp_pkg::POS_START : frame_pos + 1'b1;
    r.next_position = frame_pos;
    r.values        = published;
    expected_q.push_back(r);
  endtask

  task automatic check_result();
    parse_result_t want;
    value_set_t    got;
    got = {pm10_ambient, pm25_ambient, pm1_ambient, pm10_standard, pm25_standard, pm1_standard};
    if (expected_q.size() == 0) begin
      report_mismatch("result arrived with none expected");
    end else begin
      want = expected_q.pop_front();
      if (next_position !== want.next_position)
        report_mismatch($sformatf("next_position got %0d, expected %0d",
                                  next_position, want.next_position));
      if (frame_ok !== want.frame_ok)
        report_mismatch($sformatf("frame_ok got %0b, expected %0b", frame_ok, want.frame_ok));
      for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
        if (got[i] !== want.values[i])
          report_mismatch($sformatf("%s got %h, expected %h",
                                    value_name[i], got[i], want.values[i]));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_pos  = psfp_pkg::POS_START;
      byte_total = '0;
      check_hi   = '0;
      published  = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_byte(rx_byte);
    end
    pending_results <= expected_q.size();
    mismatch_count  <= errors;
  end

endmodule

FILE: test/particle_sensor_frame_parser_tb.sv
`timescale 1ns / 1ps
// Testbench top for particle_sensor_frame_parser: sends directed and random sensor frames
// with random idling on both sides and gives the verdict.
// Depends on psfp_pkg, particle_sensor_frame_parser and particle_sensor_frame_parser_checker.
module particle_sensor_frame_parser_tb;

  localparam int RANDOM_BYTES = 640;
  localparam int IDLE_LIMIT   = 2000;
  localparam int FRAME_BYTES  = 32;
  localparam int SUM_BYTES    = 30;

  typedef logic [psfp_pkg::NUM_VALUES-1:0][psfp_pkg::VALUE_W-1:0] value_set_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [4:0]  next_position;
  logic        frame_ok;
  logic [15:0] pm1_standard, pm25_standard, pm10_standard;
  logic [15:0] pm1_ambient, pm25_ambient, pm10_ambient;

  int          pending_results;
  int          mismatch_count;
  int          idle_cycles = 0;
  int          bytes_sent  = 0;
  bit          no_idle     = 1'b0;
  logic [7:0]  frame_buf [FRAME_BYTES];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  particle_sensor_frame_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_position (next_position),
    .frame_ok      (frame_ok),
    .pm1_standard  (pm1_standard),
    .pm25_standard (pm25_standard),
    .pm10_standard (pm10_standard),
    .pm1_ambient   (pm1_ambient),
    .pm25_ambient  (pm25_ambient),
    .pm10_ambient  (pm10_ambient)
  );

  particle_sensor_frame_parser_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .next_position   (next_position),
    .frame_ok        (frame_ok),
    .pm1_standard    (pm1_standard),
    .pm25_standard   (pm25_standard),
    .pm10_standard   (pm10_standard),
    .pm1_ambient     (pm1_ambient),
    .pm25_ambient    (pm25_ambient),
    .pm10_ambient    (pm10_ambient),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // builds one frame; bad_check flips one bit of the check word
  task automatic fill_frame(input logic [7:0] start, input value_set_t vals,
                            input bit bad_check);
    logic [15:0] check;
    frame_buf[0] = start;
    frame_buf[1] = psfp_pkg::SECOND_BYTE;
    for (int i = 2; i < FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
    for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
      frame_buf[4 + 2*i] = vals[i][15:8];
      frame_buf[5 + 2*i] = vals[i][7:0];
    end
    check = '0;
    for (int i = 0; i < SUM_BYTES; i++) check = check + 16'(frame_buf[i]);
    if (bad_check) check = check ^ (16'h1 << $urandom_range(0, 15));
    frame_buf[30] = check[15:8];
    frame_buf[31] = check[7:0];
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i]);
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_ready <= 1'b1;
      repeat (r < 20 ? $urandom_range(20, 60) : $urandom_range(1, 6)) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r >= 35) begin
        out_ready <= 1'b0;
        repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    value_set_t vals;
    int         base;
    int         kind;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bad start bytes, bad second bytes, then frames at the value extremes
    no_idle = 1'b1;
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h43);
    send_byte(psfp_pkg::SECOND_BYTE);
    send_byte(psfp_pkg::START_A);
    send_byte(8'h4c);
    send_byte(psfp_pkg::START_B);
    send_byte(psfp_pkg::START_A);
    send_byte(8'hff);
    no_idle = 1'b0;
    fill_frame(psfp_pkg::START_B, '1, 1'b0);
    send_frame(FRAME_BYTES);
    fill_frame(psfp_pkg::START_A, '0, 1'b1);
    send_frame(FRAME_BYTES);
    fill_frame(psfp_pkg::START_A, '0, 1'b0);
    send_frame(FRAME_BYTES);
    drain();

    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) vals[i] = pick_value();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        fill_frame($urandom_range(0, 1) ? psfp_pkg::START_A : psfp_pkg::START_B, vals, 1'b0);
        send_frame(FRAME_BYTES);
      end else if (kind < 80) begin
        fill_frame($urandom_range(0, 1) ? psfp_pkg::START_A : psfp_pkg::START_B, vals, 1'b1);
        send_frame(FRAME_BYTES);
      end else if (kind < 88) begin
        fill_frame($urandom_range(0, 1) ? psfp_pkg::START_A : psfp_pkg::START_B, vals, 1'b0);
        send_frame($urandom_range(1, FRAME_BYTES - 1));
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        drain();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
